// ===== rtl/ttne_pkg.sv =====
// Shared types and constants for the token table name expander.
`default_nettype none

package ttne_pkg;

  localparam logic [1:0] MODE_LOAD_INDEX = 2'd0;
  localparam logic [1:0] MODE_LOAD_TOKEN = 2'd1;
  localparam logic [1:0] MODE_LENGTH     = 2'd2;
  localparam logic [1:0] MODE_CODE       = 2'd3;

  localparam logic [1:0] KIND_CHAR     = 2'd0;
  localparam logic [1:0] KIND_DONE     = 2'd1;
  localparam logic [1:0] KIND_TOO_LONG = 2'd2;

  localparam logic [9:0] LIMIT_RESET = 10'd128;
  localparam int         INDEX_SLOTS = 256;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;
  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_AW    = 2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] table_address;
    logic [15:0] table_word;
    logic [7:0]  stream_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_char;
    logic [8:0] name_length;
    logic       last;
  } res_t;

  typedef enum logic [1:0] {
    OP_LOAD_INDEX,
    OP_LOAD_TOKEN,
    OP_LENGTH,
    OP_CODE
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [11:0] addr;
    logic [15:0] word;
    logic [7:0]  sbyte;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INDEX,
    ST_REDUCE,
    ST_WALK,
    ST_FINISH
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/ttne_front.sv =====
// Front end: accepts input transactions, classifies them and queues commands.
`default_nettype none

module ttne_front import ttne_pkg::*; #(
  parameter int TABLE_BYTES = 4096
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  input  wire in_item_t in_item_i,
  output logic          full,
  output logic          cmd_valid_o,
  output cmd_t          cmd_o,
  input  wire logic     cmd_pop_i
);

  cmd_t                 q_mem [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [CMDQ_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CMDQ_AW:0]     cnt_q, cnt_d;
  logic                 accept;
  logic                 keep;
  logic                 wr_en;
  cmd_t                 cls;

  assign full        = (cnt_q == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign accept      = push && !full;

  always_comb begin
    cls.addr  = in_item_i.table_address;
    cls.word  = in_item_i.table_word;
    cls.sbyte = in_item_i.stream_byte;
    cls.op    = OP_CODE;
    keep      = 1'b1;
    unique case (in_item_i.mode)
      MODE_LOAD_INDEX: begin
        cls.op = OP_LOAD_INDEX;
        keep   = (32'(in_item_i.table_address) < INDEX_SLOTS);
      end
      MODE_LOAD_TOKEN: begin
        cls.op = OP_LOAD_TOKEN;
        keep   = (32'(in_item_i.table_address) < TABLE_BYTES);
      end
      MODE_LENGTH: begin
        cls.op = OP_LENGTH;
      end
      MODE_CODE: begin
        cls.op = OP_CODE;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Drop out-of-range loads here.
  assign wr_en = accept && keep;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (CMDQ_AW + 1)'(wr_en) - (CMDQ_AW + 1)'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ttne_back.sv =====
// Back end: table memories, name state and the token walk sequencer.
`default_nettype none

module ttne_back import ttne_pkg::*; #(
  parameter int TABLE_BYTES   = 4096,
  parameter int MAX_TOKEN_LEN = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [9:0] cfg_data_i,
  input  wire logic       cmd_valid_i,
  input  wire cmd_t       cmd_i,
  output logic            cmd_pop_o,
  input  wire logic       resq_full_i,
  output logic            res_push_o,
  output res_t            res_o
);

  localparam int AW        = $clog2(TABLE_BYTES);
  localparam int RedQuot   = 65535 / TABLE_BYTES;
  localparam int RedRaw    = $clog2(RedQuot + 1);
  localparam int RED_STEPS = (RedRaw < 1) ? 1 : RedRaw;
  localparam int SCW       = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam int WCW       = $clog2(MAX_TOKEN_LEN + 1);

  logic [15:0] idx_mem [INDEX_SLOTS];
  logic [7:0]  tok_mem [TABLE_BYTES];

  back_state_e    state_q, state_d;
  logic [9:0]     limit_q, limit_d;
  logic [7:0]     bytes_left_q, bytes_left_d;
  logic [9:0]     room_q, room_d;
  logic [8:0]     emitted_q, emitted_d;
  logic           first_q, first_d;
  logic           stopped_q, stopped_d;
  res_t           pend_q, pend_d;
  logic           pend_vld_q, pend_vld_d;
  logic [15:0]    ptr_q, ptr_d;
  logic [SCW-1:0] step_q, step_d;
  logic [AW-1:0]  rd_addr_q, rd_addr_d;
  logic [WCW-1:0] walk_cnt_q, walk_cnt_d;
  logic           rd_vld_q, rd_vld_d;
  logic [15:0]    idx_rd_q;
  logic [7:0]     tok_rd_q;

  logic           idx_rd_en;
  logic           tok_rd_en;
  logic           idx_we;
  logic           tok_we;
  logic [15:0]    tok_wa_full;
  logic [AW-1:0]  tok_wa;
  logic [31:0]    red_cand;
  logic [15:0]    ptr_red;
  logic [AW-1:0]  rd_addr_inc;
  logic           in_walk;
  logic           c_zero;
  logic           emit;
  logic           stall;
  logic           walk_end;
  logic           fin_emit;
  logic           fin_stall;
  logic           too_long;

  assign cmd_pop_o   = (state_q == ST_IDLE) && cmd_valid_i && !pend_vld_q;
  assign idx_we      = cmd_pop_o && (cmd_i.op == OP_LOAD_INDEX);
  assign tok_we      = cmd_pop_o && (cmd_i.op == OP_LOAD_TOKEN);
  assign idx_rd_en   = cmd_pop_o && (cmd_i.op == OP_CODE) && (bytes_left_q != '0);
  assign tok_wa_full = {4'b0000, cmd_i.addr};
  assign tok_wa      = tok_wa_full[AW-1:0];
  assign too_long    = ({2'b00, cmd_i.sbyte} >= limit_q);

  assign red_cand = 32'(TABLE_BYTES) << step_q;
  assign ptr_red  = (32'(ptr_q) >= red_cand) ? 16'(32'(ptr_q) - red_cand) : ptr_q;

  assign rd_addr_inc = (rd_addr_q == AW'(TABLE_BYTES - 1)) ? '0 : rd_addr_q + 1'b1;

  assign in_walk   = (state_q == ST_WALK);
  assign c_zero    = (tok_rd_q == 8'd0);
  assign emit      = in_walk && rd_vld_q && !c_zero && first_q && !stopped_q &&
                     (room_q > 10'd1);
  assign stall     = emit && pend_vld_q && resq_full_i;
  assign walk_end  = rd_vld_q ? c_zero : (walk_cnt_q == WCW'(MAX_TOKEN_LEN));
  assign tok_rd_en = in_walk && !stall && !walk_end && (walk_cnt_q < WCW'(MAX_TOKEN_LEN));
  assign fin_emit  = (bytes_left_q == '0);
  assign fin_stall = fin_emit && pend_vld_q && resq_full_i;

  assign res_o = pend_q;

  always_comb begin
    res_push_o = 1'b0;
    unique case (state_q)
      ST_IDLE:   res_push_o = pend_vld_q && !resq_full_i;
      ST_WALK:   res_push_o = emit && pend_vld_q && !stall;
      ST_FINISH: res_push_o = fin_emit && pend_vld_q && !fin_stall;
      default:   res_push_o = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (idx_rd_en) begin
          state_d = ST_INDEX;
        end
      end
      ST_INDEX: begin
        state_d = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (step_q == '0) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_end && !stall) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!fin_stall) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath updates.
  always_comb begin
    limit_d      = cfg_we_i ? cfg_data_i : limit_q;
    bytes_left_d = bytes_left_q;
    room_d       = room_q;
    emitted_d    = emitted_q;
    first_d      = first_q;
    stopped_d    = stopped_q;
    pend_d       = pend_q;
    pend_vld_d   = pend_vld_q;
    ptr_d        = ptr_q;
    step_d       = step_q;
    rd_addr_d    = rd_addr_q;
    walk_cnt_d   = walk_cnt_q;
    rd_vld_d     = rd_vld_q;
    unique case (state_q)
      ST_IDLE: begin
        if (res_push_o) begin
          pend_vld_d = 1'b0;
        end
        if (cmd_pop_o) begin
          unique case (cmd_i.op) inside
            OP_LENGTH: begin
              if (too_long) begin
                bytes_left_d = '0;
                pend_d       = '{kind: KIND_TOO_LONG, out_char: 8'd0,
                                 name_length: 9'd0, last: 1'b1};
                pend_vld_d   = 1'b1;
              end else begin
                bytes_left_d = cmd_i.sbyte;
                room_d       = limit_q;
                emitted_d    = '0;
                first_d      = 1'b0;
                stopped_d    = 1'b0;
                if (cmd_i.sbyte == 8'd0) begin
                  pend_d     = '{kind: KIND_DONE, out_char: 8'd0,
                                 name_length: 9'd0, last: 1'b1};
                  pend_vld_d = 1'b1;
                end
              end
            end
            OP_CODE: begin
              if (idx_rd_en) begin
                bytes_left_d = bytes_left_q - 8'd1;
              end
            end
            OP_LOAD_INDEX, OP_LOAD_TOKEN: begin
              pend_vld_d = pend_vld_q;
            end
            default: begin
              pend_vld_d = pend_vld_q;
            end
          endcase
        end
      end
      ST_INDEX: begin
        ptr_d  = idx_rd_q;
        step_d = SCW'(RED_STEPS - 1);
      end
      ST_REDUCE: begin
        ptr_d  = ptr_red;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          rd_addr_d  = ptr_red[AW-1:0];
          walk_cnt_d = '0;
          rd_vld_d   = 1'b0;
        end
      end
      ST_WALK: begin
        if (!stall) begin
          if (rd_vld_q && !c_zero) begin
            if (!first_q) begin
              first_d = 1'b1;
            end else if (!stopped_q) begin
              if (room_q <= 10'd1) begin
                stopped_d = 1'b1;
              end else begin
                room_d     = room_q - 10'd1;
                emitted_d  = (emitted_q == 9'h1FF) ? emitted_q : emitted_q + 9'd1;
                pend_d     = '{kind: KIND_CHAR, out_char: tok_rd_q,
                               name_length: (emitted_q == 9'h1FF) ? emitted_q
                                                                  : emitted_q + 9'd1,
                               last: 1'b0};
                pend_vld_d = 1'b1;
              end
            end
          end
          rd_vld_d = tok_rd_en;
          if (tok_rd_en) begin
            rd_addr_d  = rd_addr_inc;
            walk_cnt_d = walk_cnt_q + 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (fin_emit) begin
          if (!fin_stall) begin
            pend_d     = '{kind: KIND_DONE, out_char: 8'd0,
                           name_length: emitted_q, last: 1'b1};
            pend_vld_d = 1'b1;
          end
        end else if (pend_vld_q) begin
          pend_d.last = 1'b1;
        end
      end
      default: begin
        pend_vld_d = pend_vld_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      limit_q      <= LIMIT_RESET;
      bytes_left_q <= '0;
      room_q       <= '0;
      emitted_q    <= '0;
      first_q      <= 1'b0;
      stopped_q    <= 1'b0;
      pend_vld_q   <= 1'b0;
      step_q       <= '0;
      walk_cnt_q   <= '0;
      rd_vld_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      limit_q      <= limit_d;
      bytes_left_q <= bytes_left_d;
      room_q       <= room_d;
      emitted_q    <= emitted_d;
      first_q      <= first_d;
      stopped_q    <= stopped_d;
      pend_vld_q   <= pend_vld_d;
      step_q       <= step_d;
      walk_cnt_q   <= walk_cnt_d;
      rd_vld_q     <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q    <= pend_d;
    ptr_q     <= ptr_d;
    rd_addr_q <= rd_addr_d;
  end

  always_ff @(posedge clk_i) begin
    if (idx_we) begin
      idx_mem[cmd_i.addr[7:0]] <= cmd_i.word;
    end
    if (idx_rd_en) begin
      idx_rd_q <= idx_mem[cmd_i.sbyte];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_we) begin
      tok_mem[tok_wa] <= cmd_i.word[7:0];
    end
    if (tok_rd_en) begin
      tok_rd_q <= tok_mem[rd_addr_q];
    end
  end

`ifndef SYNTHESIS
  a_push_has_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !resq_full_i)
    else $error("result pushed into a full queue");

  a_walk_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_walk |-> (walk_cnt_q <= WCW'(MAX_TOKEN_LEN)))
    else $error("token walk ran past its length bound");

  a_bytes_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |=> $stable(bytes_left_q))
    else $error("byte count changed outside idle");

  a_idle_pend_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && pend_vld_q) |-> pend_q.last)
    else $error("held result lacks its last flag between transactions");

  a_walk_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_walk |-> (32'(rd_addr_q) < TABLE_BYTES))
    else $error("token read address out of table");
`endif

endmodule

`default_nettype wire

// ===== rtl/ttne_resq.sv =====
// Result queue between the back end and the result ports.
`default_nettype none

module ttne_resq import ttne_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic res_push_i,
  input  wire res_t res_i,
  output logic      full_o,
  output logic      empty,
  input  wire logic pop,
  output res_t      res_o
);

  res_t               q_mem [RESQ_DEPTH];
  logic [RESQ_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [RESQ_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [RESQ_AW:0]   cnt_q, cnt_d;
  logic               do_pop;

  assign full_o = (cnt_q == (RESQ_AW + 1)'(RESQ_DEPTH));
  assign empty  = (cnt_q == '0);
  assign res_o  = q_mem[rd_ptr_q];
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_d = res_push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (RESQ_AW + 1)'(res_push_i) - (RESQ_AW + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push_i) begin
      q_mem[wr_ptr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/token_table_name_expander.sv =====
// Top level of the token table name expander.
`default_nettype none

// Expands token-compressed, length-prefixed names through a 256-entry index
// and a byte table of zero-terminated tokens; both tables come up unwritten
// and need no clearing pass. Load transactions are written without leaving
// idle. A compressed byte holds the back end while its index entry is read,
// reduced into the table by repeated subtraction of shifted table sizes, and
// its token characters are walked (up to MAX_TOKEN_LEN, ending on the
// terminator or the length bound); the next command waits until the last
// result is released, and a full result queue stalls the walk. The single
// read port of the token table sets the pace of one character per cycle
// while the result queue has room. A two-entry command queue in front and a
// four-entry result queue behind let either side stall on its own.
module token_table_name_expander import ttne_pkg::*; #(
  parameter int TABLE_BYTES   = 4096,
  parameter int MAX_TOKEN_LEN = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  input  wire in_item_t   in_item_i,
  output logic            full,
  output logic            empty,
  input  wire logic       pop,
  output res_t            res_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [9:0] cfg_data_i
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic resq_full;
  logic res_push;
  res_t res_pend;

  assign cfg_ready_o = 1'b1;

  ttne_front #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_item_i  (in_item_i),
    .full       (full),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  ttne_back #(
    .TABLE_BYTES  (TABLE_BYTES),
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .resq_full_i(resq_full),
    .res_push_o (res_push),
    .res_o      (res_pend)
  );

  ttne_resq u_resq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_push_i(res_push),
    .res_i     (res_pend),
    .full_o    (resq_full),
    .empty     (empty),
    .pop       (pop),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb_token_table_name_expander.sv =====
// Self-checking testbench for the token table name expander.
`timescale 1ns / 100ps

module tb_token_table_name_expander;
  import ttne_pkg::*;

  localparam int TBL_BYTES   = 4096;
  localparam int TOK_MAX     = 32;
  localparam int SETTLE      = 150;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 1000000;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     push        = 1'b0;
  in_item_t in_item     = '0;
  logic     full;
  logic     empty;
  logic     pop         = 1'b0;
  res_t     res_o;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  logic [9:0] cfg_data_i = '0;

  token_table_name_expander #(
    .TABLE_BYTES  (TBL_BYTES),
    .MAX_TOKEN_LEN(TOK_MAX)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_item_i  (in_item),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  in_item_t name_stream[$];
  res_t     expansion_due[$];
  int       mismatches = 0;
  int       n_items    = 0;
  int       cycles     = 0;
  bit       quiet      = 1'b0;
  int       hold_req   = 0;
  int       hold_seen  = 0;
  int       hold_cnt   = 0;
  int       send_gap   = 0;
  int       take_gap   = 0;
  logic     nxt_push;
  in_item_t nxt_item;

  // expander shadow, advanced on every accepted transaction
  logic [15:0] p_index [INDEX_SLOTS];
  logic [7:0]  p_token [TBL_BYTES];
  logic [7:0]  p_left    = '0;
  logic [9:0]  p_room    = '0;
  logic [8:0]  p_count   = '0;
  logic        p_dropped = 1'b0;
  logic        p_halted  = 1'b0;
  logic [9:0]  p_limit   = LIMIT_RESET;

  // stimulus-side view of the tables, used to keep every walk on written bytes
  logic [15:0] g_index    [INDEX_SLOTS];
  bit          g_index_ok [INDEX_SLOTS];
  logic [7:0]  g_token    [TBL_BYTES];
  bit          g_token_ok [TBL_BYTES];
  int          g_slots[$];
  int          g_left  = 0;
  int          g_limit = LIMIT_RESET;

  task automatic predict_expansion(input in_item_t it);
    res_t r;
    res_t batch[$];
    logic [15:0] ptr;
    logic [7:0] c;
    case (it.mode)
      MODE_LOAD_INDEX: begin
        if (it.table_address < INDEX_SLOTS) p_index[it.table_address[7:0]] = it.table_word;
      end
      MODE_LOAD_TOKEN: begin
        p_token[it.table_address] = it.table_word[7:0];
      end
      MODE_LENGTH: begin
        if ({2'b00, it.stream_byte} >= p_limit) begin
          p_left = '0;
          r = '{kind: KIND_TOO_LONG, out_char: 8'h00, name_length: 9'd0, last: 1'b0};
          batch.push_back(r);
        end else begin
          p_left    = it.stream_byte;
          p_room    = p_limit;
          p_count   = '0;
          p_dropped = 1'b0;
          p_halted  = 1'b0;
          if (it.stream_byte == 8'h00) begin
            r = '{kind: KIND_DONE, out_char: 8'h00, name_length: 9'd0, last: 1'b0};
            batch.push_back(r);
          end
        end
      end
      MODE_CODE: begin
        if (p_left != 8'h00) begin
          p_left = p_left - 8'd1;
          ptr = p_index[it.stream_byte];
          for (int i = 0; i < TOK_MAX; i++) begin
            c = p_token[(ptr + i) % TBL_BYTES];
            if (c == 8'h00) break;
            if (!p_dropped) begin
              p_dropped = 1'b1;
            end else if (!p_halted) begin
              if (p_room <= 10'd1) begin
                p_halted = 1'b1;
              end else begin
                p_room = p_room - 10'd1;
                if (p_count < 9'd511) p_count = p_count + 9'd1;
                r = '{kind: KIND_CHAR, out_char: c, name_length: p_count, last: 1'b0};
                batch.push_back(r);
              end
            end
          end
          if (p_left == 8'h00) begin
            r = '{kind: KIND_DONE, out_char: 8'h00, name_length: p_count, last: 1'b0};
            batch.push_back(r);
          end
        end
      end
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) expansion_due.push_back(batch[k]);
  endtask

  task automatic add_item(input logic [1:0] m, input int addr, input int word, input int sb);
    in_item_t it;
    it.mode          = m;
    it.table_address = 12'(addr);
    it.table_word    = 16'(word);
    it.stream_byte   = 8'(sb);
    case (m)
      MODE_LOAD_INDEX: begin
        if (it.table_address < INDEX_SLOTS) begin
          g_index[it.table_address[7:0]]    = it.table_word;
          g_index_ok[it.table_address[7:0]] = 1'b1;
          g_slots.push_back(int'(it.table_address));
        end
      end
      MODE_LOAD_TOKEN: begin
        g_token[it.table_address]    = it.table_word[7:0];
        g_token_ok[it.table_address] = 1'b1;
      end
      MODE_LENGTH: g_left = (int'(it.stream_byte) >= g_limit) ? 0 : int'(it.stream_byte);
      MODE_CODE:   if (g_left > 0) g_left--;
    endcase
    name_stream.push_back(it);
    n_items++;
  endtask

  function automatic bit code_safe(input int code);
    int a;
    if (!g_index_ok[code]) return 1'b0;
    for (int i = 0; i < TOK_MAX; i++) begin
      a = (int'(g_index[code]) + i) % TBL_BYTES;
      if (!g_token_ok[a]) return 1'b0;
      if (g_token[a] == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic build_token(input int slot, input int start, input int len);
    for (int i = 0; i < len && i < TOK_MAX; i++)
      add_item(MODE_LOAD_TOKEN, (start + i) % TBL_BYTES,
               ($urandom_range(0, 255) << 8) | $urandom_range(1, 255), $urandom_range(0, 255));
    if (len < TOK_MAX)
      add_item(MODE_LOAD_TOKEN, (start + len) % TBL_BYTES, $urandom_range(0, 255) << 8,
               $urandom_range(0, 255));
    add_item(MODE_LOAD_INDEX, slot, start + TBL_BYTES * $urandom_range(0, 15),
             $urandom_range(0, 255));
  endtask

  function automatic int token_len();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(28, 40);
    return $urandom_range(1, 6);
  endfunction

  task automatic pick_code(output int code);
    int s;
    code = -1;
    for (int t = 0; t < 40 && code < 0 && g_slots.size() > 0; t++) begin
      s = g_slots[$urandom_range(0, g_slots.size() - 1)];
      if (code_safe(s)) code = s;
    end
    if (code < 0) begin
      s = $urandom_range(0, 255);
      build_token(s, $urandom_range(0, TBL_BYTES - 1), $urandom_range(1, 6));
      code = s;
    end
  endtask

  task automatic gen_name();
    int r;
    int len;
    int n;
    int code;
    r = $urandom_range(0, 99);
    if (r < 6) len = 0;
    else if (r < 16 && g_limit <= 255) len = $urandom_range(g_limit, 255);
    else if (r < 22 && g_limit >= 2 && g_limit <= 64) len = g_limit - 1;
    else if (r < 28) len = $urandom_range(7, 40);
    else len = $urandom_range(1, 6);
    add_item(MODE_LENGTH, $urandom_range(0, 4095), $urandom_range(0, 65535), len);
    n = len;
    if ($urandom_range(0, 9) == 0) n = $urandom_range(0, len);
    for (int i = 0; i < n && g_left > 0; i++) begin
      pick_code(code);
      add_item(MODE_CODE, $urandom_range(0, 4095), $urandom_range(0, 65535), code);
    end
  endtask

  task automatic gen_noise();
    case ($urandom_range(0, 3))
      0: begin
        if (g_left == 0)
          add_item(MODE_CODE, $urandom_range(0, 4095), $urandom_range(0, 65535),
                   $urandom_range(0, 255));
      end
      1: add_item(MODE_LOAD_INDEX, $urandom_range(256, 4095), $urandom_range(0, 65535),
                  $urandom_range(0, 255));
      2: add_item(MODE_LOAD_TOKEN, $urandom_range(0, 4095), $urandom_range(0, 65535),
                  $urandom_range(0, 255));
      default: add_item(MODE_LOAD_INDEX, $urandom_range(0, 255), $urandom_range(0, 65535),
                        $urandom_range(0, 255));
    endcase
  endtask

  task automatic run_random(input int count);
    int stop;
    int r;
    stop = n_items + count;
    while (n_items < stop) begin
      r = $urandom_range(0, 99);
      if (r < 18) build_token($urandom_range(0, 255), $urandom_range(0, TBL_BYTES - 1), token_len());
      else if (r < 85) gen_name();
      else gen_noise();
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (name_stream.size() != 0 || push || expansion_due.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_limit(input int v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= 10'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    p_limit = 10'(v);
    g_limit = v;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push    <= 1'b0;
      in_item <= '0;
    end else begin
      nxt_push = push;
      nxt_item = in_item;
      if (push && !full) begin
        predict_expansion(in_item);
        void'(name_stream.pop_front());
        nxt_push = 1'b0;
      end
      if (!nxt_push) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 10);
        end else if (name_stream.size() > 0) begin
          nxt_push = 1'b1;
          nxt_item = name_stream[0];
        end
      end
      push    <= nxt_push;
      in_item <= nxt_item;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expansion_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result kind=%0d char=%h length=%0d last=%b", $time,
                   res_o.kind, res_o.out_char, res_o.name_length, res_o.last);
        end else begin
          want = expansion_due.pop_front();
          if (res_o.kind !== want.kind) begin
            mismatches++;
            $display("%0t: kind expected %0d, got %0d", $time, want.kind, res_o.kind);
          end
          if (res_o.out_char !== want.out_char) begin
            mismatches++;
            $display("%0t: out_char expected %h, got %h", $time, want.out_char, res_o.out_char);
          end
          if (res_o.name_length !== want.name_length) begin
            mismatches++;
            $display("%0t: name_length expected %0d, got %0d", $time, want.name_length,
                     res_o.name_length);
          end
          if (res_o.last !== want.last) begin
            mismatches++;
            $display("%0t: last expected %b, got %b", $time, want.last, res_o.last);
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_cnt  = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        take_gap = $urandom_range(0, 10);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_token_table_name_expander failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_item(MODE_LOAD_INDEX, 4095, 16'hFFFF, 0);
    add_item(MODE_CODE, 0, 0, 8'hFF);
    build_token(255, TBL_BYTES - 2, 3);
    build_token(0, 4000, 1);
    build_token(1, 200, 0);
    add_item(MODE_LENGTH, 0, 0, 0);
    add_item(MODE_LENGTH, 0, 0, 128);
    add_item(MODE_LENGTH, 0, 0, 255);
    add_item(MODE_LENGTH, 0, 0, 127);
    add_item(MODE_LENGTH, 0, 0, 4);
    add_item(MODE_CODE, 0, 0, 0);
    add_item(MODE_CODE, 0, 0, 1);
    add_item(MODE_CODE, 0, 0, 255);
    add_item(MODE_CODE, 0, 0, 255);
    add_item(MODE_LENGTH, 0, 0, 2);
    add_item(MODE_CODE, 0, 0, 255);
    add_item(MODE_LENGTH, 0, 0, 1);
    add_item(MODE_CODE, 0, 0, 255);
    run_random(50);

    wait_idle();
    set_limit(1);
    run_random(25);

    wait_idle();
    set_limit(512);
    hold_req++;
    run_random(60);

    wait_idle();
    set_limit(3);
    run_random(50);

    wait_idle();
    set_limit($urandom_range(4, 511));
    run_random(60);

    wait_idle();
    quiet = 1'b1;
    set_limit($urandom_range(1, 512));
    run_random(60);

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_token_table_name_expander passed");
    end else begin
      $display("tb_token_table_name_expander failed");
    end
    $finish;
  end

endmodule
